// File: hw/rtl/char_lcd_nibble_queue_sender_core_macros.svh
// Assertion helpers used by the nibble queue sender engine.
`ifndef CHAR_LCD_NIBBLE_QUEUE_SENDER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_QUEUE_SENDER_CORE_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define CLNQS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Trigger in this cycle implies the consequence in the next one.
`define CLNQS_ASSERT_NEXT(name, trig, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/clnqs_pkg.sv
package clnqs_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int LEVEL_W     = 6;
   localparam int MAX_BURST   = 14;
   localparam int BURST_W     = $clog2(MAX_BURST + 1);
   localparam int CSR_ADDR_W  = 2;

   // Opcodes
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_CHAR     = 3'd1;
   localparam logic [2:0] OP_POSITION = 3'd2;
   localparam logic [2:0] OP_CLEAR    = 3'd3;
   localparam logic [2:0] OP_INIT     = 3'd4;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_SHORT_DELAY  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MEDIUM_DELAY = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LONG_DELAY   = 2'd2;

   localparam logic [7:0] SHORT_DELAY_RESET  = 8'd2;
   localparam logic [7:0] MEDIUM_DELAY_RESET = 8'd3;
   localparam logic [7:0] LONG_DELAY_RESET   = 8'd106;

   // Queue entry layout: nibble in [3:0], delay flags, RS on top
   localparam int ENT_SHORT_BIT = 4;
   localparam int ENT_MED_BIT   = 5;
   localparam int ENT_LONG_BIT  = 6;
   localparam int ENT_RS_BIT    = 7;

   localparam logic [7:0] ENT_RS    = 8'h80;
   localparam logic [7:0] ENT_MED   = 8'h20;
   localparam logic [7:0] ENT_SHORT = 8'h10;
   localparam logic [7:0] CMD_LINE0 = 8'h08;
   localparam logic [7:0] CMD_LINE1 = 8'h0C;
   localparam logic [7:0] CLR_HI    = 8'h00;
   localparam logic [7:0] CLR_LO    = 8'h41;

   localparam logic [BURST_W-1:0] LEN_NONE  = BURST_W'(0);
   localparam logic [BURST_W-1:0] LEN_PAIR  = BURST_W'(2);
   localparam logic [BURST_W-1:0] LEN_INIT  = BURST_W'(MAX_BURST);

   typedef struct packed {
      logic                          is_cmd;
      logic [BURST_W-1:0]            len;
      logic [MAX_BURST-1:0][7:0]     entries;
   } burst_type;

   typedef struct packed {
      logic               sent;
      logic               register_select;
      logic [3:0]         data_nibble;
      logic               busy_res;
      logic               dropped;
      logic [LEVEL_W-1:0] queue_level;
   } result_type;

   function automatic logic [7:0] init_entry(input logic [BURST_W-1:0] idx);
      logic [7:0] e;
      case (idx)
         4'd0:    e = 8'h13;
         4'd1:    e = 8'h13;
         4'd2:    e = 8'h13;
         4'd3:    e = 8'h12;
         4'd4:    e = 8'h02;
         4'd5:    e = 8'h18;
         4'd6:    e = 8'h00;
         4'd7:    e = 8'h1C;
         4'd8:    e = 8'h00;
         4'd9:    e = 8'h41;
         4'd10:   e = 8'h00;
         4'd11:   e = 8'h16;
         4'd12:   e = 8'h00;
         4'd13:   e = 8'h41;
         default: e = 8'h00;
      endcase
      return e;
   endfunction

endpackage

// File: hw/rtl/clnqs_expand.sv
module clnqs_expand
   import clnqs_pkg::*;
(
   input  logic [2:0] opcode,
   input  logic [7:0] character,
   input  logic [3:0] column,
   input  logic       row,
   output burst_type  burst
);

   always_comb begin
      burst.is_cmd  = 1'b0;
      burst.len     = LEN_NONE;
      burst.entries = '0;
      case (opcode)
         OP_CHAR: begin
            burst.is_cmd     = 1'b1;
            burst.len        = LEN_PAIR;
            burst.entries[0] = ENT_RS | {4'd0, character[7:4]};
            burst.entries[1] = ENT_RS | ENT_MED | {4'd0, character[3:0]};
         end
         OP_POSITION: begin
            burst.is_cmd     = 1'b1;
            burst.len        = LEN_PAIR;
            burst.entries[0] = row ? CMD_LINE1 : CMD_LINE0;
            burst.entries[1] = ENT_SHORT | {4'd0, column};
         end
         OP_CLEAR: begin
            burst.is_cmd     = 1'b1;
            burst.len        = LEN_PAIR;
            burst.entries[0] = CLR_HI;
            burst.entries[1] = CLR_LO;
         end
         OP_INIT: begin
            burst.is_cmd = 1'b1;
            burst.len    = LEN_INIT;
            for (int k = 0; k < MAX_BURST; k++) begin
               burst.entries[k] = init_entry(BURST_W'(k));
            end
         end
         default: begin
            burst.is_cmd = 1'b0;
         end
      endcase
   end

endmodule

// File: hw/rtl/clnqs_engine.sv
`include "char_lcd_nibble_queue_sender_core_macros.svh"

module clnqs_engine
   import clnqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [2:0]            opcode,
   input  burst_type             burst,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [7:0]            csr_wdata,
   output result_type            result
);

   logic [7:0]       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       delay_ff, delay_in;
   logic [7:0]       short_ff, medium_ff, long_ff;

   logic [7:0]       head;
   logic             room, push, pop, drop;
   logic             med_load;
   logic [PTR_W-1:0] slot_off [QUEUE_DEPTH];
   logic             slot_we  [QUEUE_DEPTH];

   assign head = entry_ff[rd_ff];
   assign room = ((CNT_W+1)'(count_ff) + (CNT_W+1)'(burst.len)) <= (CNT_W+1)'(QUEUE_DEPTH);

   always_comb begin
      push     = 1'b0;
      pop      = 1'b0;
      drop     = 1'b0;
      delay_in = delay_ff;
      if (opcode == OP_TICK) begin
         if (delay_ff != 8'd0) begin
            delay_in = delay_ff - 8'd1;
         end else if (count_ff != '0) begin
            pop = 1'b1;
            if (head[ENT_SHORT_BIT]) delay_in = short_ff;
            else if (head[ENT_MED_BIT]) delay_in = medium_ff;
            else if (head[ENT_LONG_BIT]) delay_in = long_ff;
            else delay_in = 8'd0;
         end
      end else if (burst.is_cmd) begin
         if (room) push = 1'b1;
         else drop = 1'b1;
      end
   end

   always_comb begin
      rd_in    = pop ? rd_ff + PTR_W'(1) : rd_ff;
      wr_in    = push ? wr_ff + PTR_W'(burst.len) : wr_ff;
      count_in = count_ff;
      if (pop) count_in = count_ff - CNT_W'(1);
      else if (push) count_in = count_ff + CNT_W'(burst.len);
   end

   // Each slot picks its entry by its offset from the write pointer
   always_comb begin
      for (int s = 0; s < QUEUE_DEPTH; s++) begin
         slot_off[s] = PTR_W'(s) - wr_ff;
         slot_we[s]  = push && (slot_off[s] < PTR_W'(burst.len));
      end
   end

   always_comb begin
      result.sent            = pop;
      result.register_select = pop & head[ENT_RS_BIT];
      result.data_nibble     = pop ? head[3:0] : 4'd0;
      result.busy_res        = delay_in != 8'd0;
      result.dropped         = drop;
      result.queue_level     = LEVEL_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
         delay_ff <= '0;
      end else if (step) begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
         delay_ff <= delay_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QUEUE_DEPTH; s++) begin
         if (step && slot_we[s]) begin
            entry_ff[s] <= burst.entries[slot_off[s][BURST_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff  <= SHORT_DELAY_RESET;
         medium_ff <= MEDIUM_DELAY_RESET;
         long_ff   <= LONG_DELAY_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SHORT_DELAY:  short_ff  <= csr_wdata;
            REG_MEDIUM_DELAY: medium_ff <= csr_wdata;
            REG_LONG_DELAY:   long_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign med_load = step && pop && !head[ENT_SHORT_BIT] && head[ENT_MED_BIT];

   `CLNQS_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
   `CLNQS_ASSERT(a_ptr_gap, PTR_W'(wr_ff - rd_ff) == PTR_W'(count_ff), "pointer gap off count")
   `CLNQS_ASSERT_NEXT(a_drop_hold, step && drop, count_ff == $past(count_ff), "drop moved queue")
   `CLNQS_ASSERT_NEXT(a_send_delay, med_load, delay_ff == medium_ff, "medium delay not loaded")

endmodule

// File: hw/rtl/char_lcd_nibble_queue_sender_core.sv
// Character-LCD 4-bit nibble sender. Commands on req expand into queue entries
// (two for character, position and clear, fourteen for init); each tick counts
// down the running post-send delay, else strobes the oldest entry if one is queued and
// loads its delay from the csr registers. Every item yields one rsp transfer. An
// item is accepted every cycle while the result register is free or draining; it
// waits in the input register, then the queue update step feeds the result register.
// The 32-entry queue lives in flops and has no clearing pass after reset.
module char_lcd_nibble_queue_sender_core
   import clnqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // character[7:0], column[11:8], row[12]
   input  logic [2:0]            req_tuser,  // opcode[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // register_select[0], data_nibble[4:1],
                                             // busy_res[5], dropped[6], queue_level[12:7]
   output logic                  rsp_tuser,  // sent[0]
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [7:0]            csr_wdata
);

   logic       in_valid_ff;
   logic [2:0] opcode_ff;
   logic [7:0] character_ff;
   logic [3:0] column_ff;
   logic       row_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       step;
   burst_type  burst;
   result_type result;

   // Advance the held item when the result register is free or drains now
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         opcode_ff    <= req_tuser;
         character_ff <= req_tdata[7:0];
         column_ff    <= req_tdata[11:8];
         row_ff       <= req_tdata[12];
      end
   end

   clnqs_expand u_expand (
      .opcode    (opcode_ff),
      .character (character_ff),
      .column    (column_ff),
      .row       (row_ff),
      .burst     (burst)
   );

   clnqs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .opcode    (opcode_ff),
      .burst     (burst),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.sent;
   assign rsp_tdata  = {3'd0, out_ff.queue_level, out_ff.dropped, out_ff.busy_res,
                        out_ff.data_nibble, out_ff.register_select};

endmodule

// File: sim/char_lcd_nibble_queue_sender_core_checker.sv
`timescale 1ns / 1ps
module char_lcd_nibble_queue_sender_core_checker
   import clnqs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [15:0]           req_tdata,  // character[7:0], column[11:8], row[12]
   input  logic [2:0]            req_tuser,  // opcode[2:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,  // register_select[0], data_nibble[4:1],
                                             // busy_res[5], dropped[6], queue_level[12:7]
   input  logic                  rsp_tuser,  // sent[0]
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [7:0]            csr_wdata,
   output int                    mismatch_count,
   output int                    pending_results
);

   // Power-up sequence, first entry in the lowest byte
   localparam logic [MAX_BURST*8-1:0] POWER_UP_SEQ = {
      8'h41, 8'h00, 8'h16, 8'h00, 8'h41, 8'h00, 8'h1C,
      8'h00, 8'h18, 8'h02, 8'h12, 8'h13, 8'h13, 8'h13
   };

   logic [7:0]       lcd_fifo [QUEUE_DEPTH];
   logic [PTR_W-1:0] rd_ptr;
   logic [PTR_W-1:0] wr_ptr;
   int               fill;
   logic [7:0]       hold_ticks;
   logic [7:0]       short_ticks;
   logic [7:0]       medium_ticks;
   logic [7:0]       long_ticks;
   result_type       lcd_expected[$];
   int               results_seen;

   task automatic queue_lcd_entry(input logic [7:0] entry);
      lcd_fifo[wr_ptr] = entry;
      wr_ptr = wr_ptr + 1'b1;
      fill++;
   endtask

   task automatic predict_lcd_item(
      input  logic [2:0] op,
      input  logic [7:0] ch,
      input  logic [3:0] col,
      input  logic       row,
      output result_type res
   );
      logic [7:0] entry;
      res = '0;
      case (op)
         OP_TICK: begin
            if (hold_ticks != 8'd0) begin
               hold_ticks = hold_ticks - 8'd1;
            end else if (fill != 0) begin
               entry = lcd_fifo[rd_ptr];
               rd_ptr = rd_ptr + 1'b1;
               fill--;
               res.sent            = 1'b1;
               res.register_select = entry[ENT_RS_BIT];
               res.data_nibble     = entry[3:0];
               // short wins over medium, medium over long
               if (entry[ENT_SHORT_BIT])     hold_ticks = short_ticks;
               else if (entry[ENT_MED_BIT])  hold_ticks = medium_ticks;
               else if (entry[ENT_LONG_BIT]) hold_ticks = long_ticks;
               else                          hold_ticks = 8'd0;
            end
         end
         OP_CHAR, OP_POSITION, OP_CLEAR: begin
            if (fill + 2 > QUEUE_DEPTH) begin
               res.dropped = 1'b1;
            end else if (op == OP_CHAR) begin
               queue_lcd_entry(ENT_RS | {4'h0, ch[7:4]});
               queue_lcd_entry(ENT_RS | ENT_MED | {4'h0, ch[3:0]});
            end else if (op == OP_POSITION) begin
               queue_lcd_entry(row ? CMD_LINE1 : CMD_LINE0);
               queue_lcd_entry(ENT_SHORT | {4'h0, col});
            end else begin
               queue_lcd_entry(CLR_HI);
               queue_lcd_entry(CLR_LO);
            end
         end
         OP_INIT: begin
            if (fill + MAX_BURST > QUEUE_DEPTH) begin
               res.dropped = 1'b1;
            end else begin
               for (int i = 0; i < MAX_BURST; i++) queue_lcd_entry(POWER_UP_SEQ[i*8 +: 8]);
            end
         end
         default: ;
      endcase
      res.busy_res    = (hold_ticks != 8'd0);
      res.queue_level = LEVEL_W'(fill);
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rd_ptr          = '0;
         wr_ptr          = '0;
         fill            = 0;
         hold_ticks      = 8'd0;
         short_ticks     = SHORT_DELAY_RESET;
         medium_ticks    = MEDIUM_DELAY_RESET;
         long_ticks      = LONG_DELAY_RESET;
         results_seen    = 0;
         mismatch_count  = 0;
         lcd_expected.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_SHORT_DELAY:  short_ticks  = csr_wdata;
               REG_MEDIUM_DELAY: medium_ticks = csr_wdata;
               REG_LONG_DELAY:   long_ticks   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.sent            = rsp_tuser;
            got.register_select = rsp_tdata[0];
            got.data_nibble     = rsp_tdata[4:1];
            got.busy_res        = rsp_tdata[5];
            got.dropped         = rsp_tdata[6];
            got.queue_level     = rsp_tdata[12:7];
            if (lcd_expected.size() == 0) begin
               if (mismatch_count < 10)
                  $display("result %0d: transfer with nothing expected", results_seen);
               mismatch_count++;
            end else begin
               want = lcd_expected.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10) begin
                     $write("result %0d: expected sent=%0b rs=%0b nibble=%h busy=%0b ",
                            results_seen, want.sent, want.register_select,
                            want.data_nibble, want.busy_res);
                     $write("dropped=%0b level=%0d, got sent=%0b rs=%0b nibble=%h ",
                            want.dropped, want.queue_level, got.sent,
                            got.register_select, got.data_nibble);
                     $display("busy=%0b dropped=%0b level=%0d",
                              got.busy_res, got.dropped, got.queue_level);
                  end
                  mismatch_count++;
               end
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            predict_lcd_item(req_tuser, req_tdata[7:0], req_tdata[11:8], req_tdata[12], want);
            lcd_expected.push_back(want);
         end
      end
      pending_results = lcd_expected.size();
   end

endmodule

// File: sim/char_lcd_nibble_queue_sender_core_tb.sv
`timescale 1ns / 1ps
module char_lcd_nibble_queue_sender_core_tb;
   import clnqs_pkg::*;

   localparam logic [2:0]            OP_SPARE_FIRST  = 3'd5;
   localparam logic [2:0]            OP_SPARE_MID    = 3'd6;
   localparam logic [2:0]            OP_SPARE_LAST   = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] REG_UNMAPPED    = 2'd3;
   localparam int                    CYCLE_LIMIT     = 400000;
   localparam int                    HOLD_OFF_AT     = 150;
   localparam int                    HOLD_OFF_CYCLES = 300;
   localparam int                    SETTLE_CYCLES   = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;
   logic [2:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [7:0]            csr_wdata;
   int                    mismatch_count;
   int                    pending_results;
   int                    sender_calm;

   char_lcd_nibble_queue_sender_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   char_lcd_nibble_queue_sender_core_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_command(
      input logic [2:0] op,
      input logic [7:0] ch,
      input logic [3:0] col,
      input logic       row
   );
      int gap;
      if (sender_calm > 0) begin
         gap = 0;
         sender_calm--;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 19) == 0) sender_calm = $urandom_range(10, 40);
      end
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, row, col, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_tick();
      send_command(OP_TICK, 8'h00, 4'h0, 1'b0);
   endtask

   task automatic send_random_command(input int tick_pct);
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < tick_pct) begin
         op = OP_TICK;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      op = OP_CHAR;
         else if (pick < 65) op = OP_POSITION;
         else if (pick < 80) op = OP_CLEAR;
         else if (pick < 92) op = OP_INIT;
         else                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
      send_command(op, 8'($urandom), 4'($urandom), 1'($urandom));
   endtask

   // Drop valid, let every expected result arrive, then give the pipeline time to settle.
   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(
      input logic [7:0] short_ticks,
      input logic [7:0] medium_ticks,
      input logic [7:0] long_ticks,
      input int         tick_pct,
      input int         count
   );
      wait_quiet();
      write_csr(REG_SHORT_DELAY, short_ticks);
      write_csr(REG_MEDIUM_DELAY, medium_ticks);
      write_csr(REG_LONG_DELAY, long_ticks);
      write_csr(REG_UNMAPPED, 8'($urandom));
      repeat (count) send_random_command(tick_pct);
   endtask

   // Result side: random stalls, calm stretches, and one long hold-off to back up the pipeline.
   initial begin : rsp_side
      int stall;
      int calm;
      int taken;
      rsp_tready = 1'b0;
      calm  = 0;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken == HOLD_OFF_AT) begin
            stall = HOLD_OFF_CYCLES;
         end else if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_TICK;
      csr_we      = 1'b0;
      csr_addr    = REG_SHORT_DELAY;
      csr_wdata   = 8'h00;
      sender_calm = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty tick, spare opcodes, field extremes, then fill to the brim.
      send_tick();
      send_command(OP_SPARE_FIRST, 8'hFF, 4'hF, 1'b1);
      send_command(OP_SPARE_MID, 8'hFF, 4'hF, 1'b1);
      send_command(OP_SPARE_LAST, 8'hFF, 4'hF, 1'b1);
      send_command(OP_CHAR, 8'h00, 4'h0, 1'b0);
      send_command(OP_CHAR, 8'hFF, 4'h0, 1'b0);
      send_command(OP_POSITION, 8'h00, 4'h0, 1'b0);
      send_command(OP_POSITION, 8'h00, 4'hF, 1'b1);
      send_command(OP_CLEAR, 8'h00, 4'h0, 1'b0);
      send_command(OP_INIT, 8'h00, 4'h0, 1'b0);
      send_command(OP_INIT, 8'h00, 4'h0, 1'b0);
      send_command(OP_CHAR, 8'hA5, 4'h0, 1'b0);
      send_command(OP_POSITION, 8'h00, 4'h7, 1'b1);
      send_command(OP_CLEAR, 8'h00, 4'h0, 1'b0);
      send_command(OP_CHAR, 8'h5A, 4'h0, 1'b0);
      send_command(OP_CHAR, 8'h33, 4'h0, 1'b0);
      send_command(OP_INIT, 8'h00, 4'h0, 1'b0);
      // Second tick hits the medium delay and keeps counting it down.
      repeat (8) send_tick();

      run_phase(SHORT_DELAY_RESET, MEDIUM_DELAY_RESET, LONG_DELAY_RESET, 70, 200);
      run_phase(8'd0, 8'd0, 8'd0, 90, 200);
      run_phase(8'd255, 8'd255, 8'd255, 60, 150);
      run_phase(8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                8'($urandom_range(0, 8)), 75, 250);
      run_phase(8'($urandom), 8'd1, 8'($urandom_range(0, 20)), 85, 200);
      wait_quiet();

      if (mismatch_count == 0 && pending_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/clnqs_pkg.sv
hw/rtl/clnqs_expand.sv
hw/rtl/clnqs_engine.sv
hw/rtl/char_lcd_nibble_queue_sender_core.sv
sim/char_lcd_nibble_queue_sender_core_checker.sv
sim/char_lcd_nibble_queue_sender_core_tb.sv
